### rtl/traffic_lane_ca_step_unit_assert.svh
// assertion macros used by the checker file tlca_check.sv
`ifndef TRAFFIC_LANE_CA_STEP_UNIT_ASSERT_SVH
`define TRAFFIC_LANE_CA_STEP_UNIT_ASSERT_SVH

// same-cycle implication, disabled in reset
`define TLCA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tlca check failed");

// next-cycle implication, disabled in reset
`define TLCA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tlca check failed");

`endif

### rtl/tlca_pkg.sv
// shared types, constants and helper functions for the traffic lane step unit
package tlca_pkg;

  localparam int MAX_CARS = 64;
  localparam int SLOT_W   = 6;
  localparam int CNT_W    = 7;
  localparam int POS_W    = 10;
  localparam int SPD_W    = 4;
  localparam int LEN_W    = 11;
  localparam int THR_W    = 17;
  localparam int LFSR_W   = 16;
  localparam int GAP_W    = 13;
  localparam int CFG_W    = 17;
  localparam int FLOW_W   = 32;

  localparam logic [LEN_W-1:0]  ROAD_RESET = 11'd10;
  localparam logic [THR_W-1:0]  SLOW_RESET = 17'd64881;
  localparam logic [THR_W-1:0]  TWO_RESET  = 17'd32768;
  localparam logic [LFSR_W-1:0] SEED_RESET = 16'd44257;

  typedef enum logic [1:0] {
    KIND_CLEAR  = 2'd0,
    KIND_APPEND = 2'd1,
    KIND_STEP   = 2'd2,
    KIND_READ   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    CFG_ROAD_LENGTH = 2'd0,
    CFG_SLOW_THR    = 2'd1,
    CFG_TWO_THR     = 2'd2,
    CFG_SEED        = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_CLEAR,
    OP_APPEND,
    OP_P12,
    OP_P34,
    OP_P56
  } op_t;

  typedef struct packed {
    op_t  op;
    logic load;
  } ctl_cmd_t;

  typedef struct packed {
    logic busy;
    logic empty;
  } dp_status_t;

  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic [POS_W-1:0] prev;
    logic [SPD_W-1:0] spd;
    logic [SPD_W-1:0] top;
    logic             look;
  } car_t;

  function automatic logic [LFSR_W-1:0] lfsr_next(input logic [LFSR_W-1:0] v);
    return {v[0] ^ v[2] ^ v[3] ^ v[5], v[LFSR_W-1:1]};
  endfunction

  function automatic logic signed [GAP_W-1:0] wrap_gap(input logic [POS_W-1:0] ahead,
                                                       input logic [POS_W-1:0] own,
                                                       input logic [LEN_W-1:0] len);
    logic signed [GAP_W-1:0] d;
    d = $signed({{(GAP_W-POS_W){1'b0}}, ahead}) - $signed({{(GAP_W-POS_W){1'b0}}, own});
    if (d < 0) begin
      d = d + $signed({{(GAP_W-LEN_W){1'b0}}, len});
    end
    return d;
  endfunction

  function automatic logic [SPD_W-1:0] limit_speed(input logic [SPD_W-1:0] s,
                                                   input logic signed [GAP_W-1:0] b);
    logic [SPD_W-1:0] r;
    r = s;
    if (b < 0) begin
      r = '0;
    end else if (b < $signed({{(GAP_W-SPD_W){1'b0}}, s})) begin
      r = b[SPD_W-1:0];
    end
    return r;
  endfunction

endpackage

### rtl/traffic_lane_ca_step_unit.sv
// top level of the traffic lane cellular automaton step unit
// One item is worked on at a time; the next item is taken while a result waits in the output
// register. A step on n cars runs three sweeps over the car memories (draw and accelerate,
// slow-to-start and gap limits, collision limit and move), each reading one car per cycle
// through the single read port plus two wrap reads.
module traffic_lane_ca_step_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  tlca_pkg::kind_t               kind,
  input  logic [tlca_pkg::POS_W-1:0]    car_position,
  input  logic [tlca_pkg::SPD_W-1:0]    car_speed,
  input  logic [tlca_pkg::SPD_W-1:0]    car_top_speed,
  input  logic [tlca_pkg::SLOT_W-1:0]   car_slot,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [tlca_pkg::POS_W-1:0]    out_position,
  output logic [tlca_pkg::POS_W-1:0]    out_prev_position,
  output logic [tlca_pkg::SPD_W-1:0]    out_speed,
  output logic [tlca_pkg::CNT_W-1:0]    car_total,
  output logic [tlca_pkg::FLOW_W-1:0]   flow_total,
  output logic                          rejected,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [1:0]                    cfg_index,
  input  logic [tlca_pkg::CFG_W-1:0]    cfg_data
);
  import tlca_pkg::*;

  ctl_cmd_t   cmd;
  dp_status_t status;
  logic       take;

  assign cfg_ready = 1'b1;
  assign take      = in_valid && !in_stall;

  tlca_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_kind   (kind),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  tlca_datapath u_dp (
    .clk               (clk),
    .rst               (rst),
    .take              (take),
    .kind              (kind),
    .car_position      (car_position),
    .car_speed         (car_speed),
    .car_top_speed     (car_top_speed),
    .car_slot          (car_slot),
    .cfg_we            (cfg_valid && cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .cmd               (cmd),
    .status            (status),
    .out_position      (out_position),
    .out_prev_position (out_prev_position),
    .out_speed         (out_speed),
    .car_total         (car_total),
    .flow_total        (flow_total),
    .rejected          (rejected)
  );

endmodule

### rtl/tlca_ram.sv
// generic single write port, single read port ram with registered read
module tlca_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/tlca_datapath.sv
// car memories, sweep window, lfsr, counters and result register
module tlca_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          take,
  input  tlca_pkg::kind_t               kind,
  input  logic [tlca_pkg::POS_W-1:0]    car_position,
  input  logic [tlca_pkg::SPD_W-1:0]    car_speed,
  input  logic [tlca_pkg::SPD_W-1:0]    car_top_speed,
  input  logic [tlca_pkg::SLOT_W-1:0]   car_slot,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [tlca_pkg::CFG_W-1:0]    cfg_data,
  input  tlca_pkg::ctl_cmd_t            cmd,
  output tlca_pkg::dp_status_t          status,
  output logic [tlca_pkg::POS_W-1:0]    out_position,
  output logic [tlca_pkg::POS_W-1:0]    out_prev_position,
  output logic [tlca_pkg::SPD_W-1:0]    out_speed,
  output logic [tlca_pkg::CNT_W-1:0]    car_total,
  output logic [tlca_pkg::FLOW_W-1:0]   flow_total,
  output logic                          rejected
);
  import tlca_pkg::*;

  kind_t              kind_q;
  logic [POS_W-1:0]   in_pos_q;
  logic [SPD_W-1:0]   in_spd_q;
  logic [SPD_W-1:0]   in_top_q;
  logic [SLOT_W-1:0]  slot_q;

  logic [LEN_W-1:0]   road_len;
  logic [THR_W-1:0]   slow_thr;
  logic [THR_W-1:0]   two_thr;
  logic [LFSR_W-1:0]  seed;

  logic [CNT_W-1:0]   n;
  logic [FLOW_W-1:0]  flow;
  logic [LFSR_W-1:0]  lfsr;
  logic               rej_q;

  op_t                pass_q;
  logic               issuing;
  logic [CNT_W-1:0]   j;
  logic               dv;
  logic [CNT_W-1:0]   dj;
  car_t               head0;
  car_t               head1;
  car_t               wa;
  car_t               wb;
  logic [SPD_W-1:0]   spd0_new;

  car_t               rd;
  car_t               e;
  logic               proc;
  logic [CNT_W-1:0]   i;
  logic [LFSR_W-1:0]  dr;
  logic               full;
  logic               append;
  logic               slot_ok;

  logic [SPD_W-1:0]   s12;
  logic               look12;
  logic signed [GAP_W-1:0] b3;
  logic signed [GAP_W-1:0] b4;
  logic [SPD_W-1:0]   s3;
  logic [SPD_W-1:0]   s4;
  logic [SPD_W-1:0]   sa1;
  logic signed [GAP_W-1:0] b5;
  logic [SPD_W-1:0]   s5;
  logic [LEN_W-1:0]   p;
  logic [LEN_W-1:0]   pw;
  logic               wrap;

  logic [SLOT_W-1:0]  raddr;
  logic [SLOT_W-1:0]  waddr;
  logic               spd_we;
  logic               look_we;
  logic               pos_we;
  logic [SPD_W-1:0]   spd_wd;
  logic [POS_W-1:0]   pos_wd;
  logic [POS_W-1:0]   prev_wd;
  logic               look_wd;
  logic [SPD_W-1:0]   spd_sum;

  assign full    = (n == CNT_W'(MAX_CARS));
  assign append  = (cmd.op == OP_APPEND) && !full;
  assign slot_ok = ({1'b0, slot_q} < n);
  assign raddr   = issuing ? j[SLOT_W-1:0] : slot_q;

  assign e    = (dj < n) ? rd : (((dj == n + 7'd1) && (n > 7'd1)) ? head1 : head0);
  assign proc = dv && (dj >= 7'd2);
  assign i    = dj - 7'd2;
  assign dr   = lfsr_next(lfsr);

  // passes 1 and 2
  assign spd_sum = (wa.spd == '1) ? wa.spd : wa.spd + 4'd1;
  assign look12  = ({1'b0, dr} < two_thr);
  assign s12     = (wa.top < wa.spd + {3'b0, ~&wa.spd}) ? wa.top : spd_sum;

  // passes 3 and 4
  assign b3 = wa.look ? wrap_gap(e.prev, wa.prev, road_len) - 13'sd2
                      : wrap_gap(wb.prev, wa.pos, road_len) - 13'sd1;
  assign s3 = ({1'b0, dr} < slow_thr) ? limit_speed(wa.spd, b3) : wa.spd;
  assign b4 = wa.look ? wrap_gap(e.pos, wa.pos, road_len) - 13'sd2
                      : wrap_gap(wb.pos, wa.pos, road_len) - 13'sd1;
  assign s4 = limit_speed(s3, b4);

  // passes 5 and 6, the last car sees the already limited speed of car zero
  assign sa1  = ((i == n - 7'd1) && (n > 7'd1)) ? spd0_new : wb.spd;
  assign b5   = wrap_gap(wb.pos, wa.pos, road_len) - 13'sd1
              + $signed({{(GAP_W-SPD_W){1'b0}}, sa1});
  assign s5   = limit_speed(wa.spd, b5);
  assign p    = {1'b0, wa.pos} + {{(LEN_W-SPD_W){1'b0}}, s5};
  assign wrap = (p >= road_len);
  assign pw   = wrap ? p - road_len : p;

  always_comb begin
    waddr   = append ? n[SLOT_W-1:0] : i[SLOT_W-1:0];
    spd_we  = append;
    look_we = append;
    pos_we  = append;
    spd_wd  = in_spd_q;
    look_wd = 1'b0;
    pos_wd  = in_pos_q;
    prev_wd = in_pos_q;
    if (proc) begin
      unique case (pass_q)
        OP_P12: begin
          spd_we  = 1'b1;
          look_we = 1'b1;
          spd_wd  = s12;
          look_wd = look12;
        end
        OP_P34: begin
          spd_we = 1'b1;
          spd_wd = s4;
        end
        OP_P56: begin
          spd_we  = 1'b1;
          pos_we  = 1'b1;
          spd_wd  = s5;
          pos_wd  = pw[POS_W-1:0];
          prev_wd = wa.pos;
        end
        default: begin
        end
      endcase
    end
  end

  tlca_ram #(.WIDTH(POS_W), .DEPTH(MAX_CARS)) u_pos_ram (
    .clk(clk), .we(pos_we), .waddr(waddr), .wdata(pos_wd), .raddr(raddr), .rdata(rd.pos)
  );
  tlca_ram #(.WIDTH(POS_W), .DEPTH(MAX_CARS)) u_prev_ram (
    .clk(clk), .we(pos_we), .waddr(waddr), .wdata(prev_wd), .raddr(raddr), .rdata(rd.prev)
  );
  tlca_ram #(.WIDTH(SPD_W), .DEPTH(MAX_CARS)) u_spd_ram (
    .clk(clk), .we(spd_we), .waddr(waddr), .wdata(spd_wd), .raddr(raddr), .rdata(rd.spd)
  );
  tlca_ram #(.WIDTH(SPD_W), .DEPTH(MAX_CARS)) u_top_ram (
    .clk(clk), .we(append), .waddr(waddr), .wdata(in_top_q), .raddr(raddr), .rdata(rd.top)
  );
  tlca_ram #(.WIDTH(1), .DEPTH(MAX_CARS)) u_look_ram (
    .clk(clk), .we(look_we), .waddr(waddr), .wdata(look_wd), .raddr(raddr), .rdata(rd.look)
  );

  assign status.busy  = issuing | dv;
  assign status.empty = (n == '0);

  // input capture and payload
  always_ff @(posedge clk) begin
    if (take) begin
      kind_q   <= kind;
      in_pos_q <= car_position;
      in_spd_q <= car_speed;
      in_top_q <= car_top_speed;
      slot_q   <= car_slot;
    end
    if (dv) begin
      wa <= wb;
      wb <= e;
      if (dj == 7'd0) begin
        head0 <= rd;
      end
      if (dj == 7'd1) begin
        head1 <= rd;
      end
    end
    if (proc && (i == 7'd0)) begin
      spd0_new <= s5;
    end
    if (cmd.op == OP_APPEND) begin
      rej_q <= full;
    end
    if (cmd.load) begin
      out_position      <= '0;
      out_prev_position <= '0;
      out_speed         <= '0;
      car_total         <= n;
      flow_total        <= flow;
      rejected          <= 1'b0;
      unique case (kind_q)
        KIND_APPEND: rejected <= rej_q;
        KIND_READ: begin
          rejected <= !slot_ok;
          if (slot_ok) begin
            out_position      <= rd.pos;
            out_prev_position <= rd.prev;
            out_speed         <= rd.spd;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // control state of the datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      road_len <= ROAD_RESET;
      slow_thr <= SLOW_RESET;
      two_thr  <= TWO_RESET;
      seed     <= SEED_RESET;
      n        <= '0;
      flow     <= '0;
      lfsr     <= SEED_RESET;
      pass_q   <= OP_NONE;
      issuing  <= 1'b0;
      j        <= '0;
      dv       <= 1'b0;
      dj       <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_index))
          CFG_ROAD_LENGTH: road_len <= cfg_data[LEN_W-1:0];
          CFG_SLOW_THR:    slow_thr <= cfg_data[THR_W-1:0];
          CFG_TWO_THR:     two_thr  <= cfg_data[THR_W-1:0];
          CFG_SEED:        seed     <= cfg_data[LFSR_W-1:0];
        endcase
      end
      dv <= issuing;
      dj <= j;
      if (issuing) begin
        if (j == n + 7'd1) begin
          issuing <= 1'b0;
        end else begin
          j <= j + 7'd1;
        end
      end
      if (proc && ((pass_q == OP_P12) || (pass_q == OP_P34))) begin
        lfsr <= dr;
      end
      if (proc && (pass_q == OP_P56) && wrap) begin
        flow <= flow + 32'd1;
      end
      unique case (cmd.op)
        OP_CLEAR: begin
          n    <= '0;
          flow <= '0;
          lfsr <= seed;
        end
        OP_APPEND: begin
          if (!full) begin
            n <= n + 7'd1;
          end
        end
        OP_P12, OP_P34, OP_P56: begin
          pass_q  <= cmd.op;
          issuing <= 1'b1;
          j       <= '0;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

### rtl/tlca_ctrl.sv
// controller state machine sequencing commands and the passes of a step
module tlca_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  tlca_pkg::kind_t      in_kind,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  input  tlca_pkg::dp_status_t status,
  output tlca_pkg::ctl_cmd_t   cmd
);
  import tlca_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_P12,
    S_P34,
    S_P56,
    S_DONE
  } state_t;

  state_t state;
  op_t    op_q;
  logic   take;
  logic   load;
  logic   pass_end;

  assign in_stall = (state != S_IDLE);
  assign take     = in_valid && !in_stall;
  assign pass_end = (op_q == OP_NONE) && !status.busy;
  assign load     = (state == S_DONE) && (op_q == OP_NONE) && (!out_valid || !out_stall);
  assign cmd      = '{op: op_q, load: load};

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      op_q      <= OP_NONE;
      out_valid <= 1'b0;
    end else begin
      op_q <= OP_NONE;
      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (take) begin
            unique case (in_kind)
              KIND_CLEAR: begin
                op_q  <= OP_CLEAR;
                state <= S_DONE;
              end
              KIND_APPEND: begin
                op_q  <= OP_APPEND;
                state <= S_DONE;
              end
              KIND_STEP: begin
                if (status.empty) begin
                  state <= S_DONE;
                end else begin
                  op_q  <= OP_P12;
                  state <= S_P12;
                end
              end
              KIND_READ: state <= S_READ;
            endcase
          end
        end
        S_READ: state <= S_DONE;
        S_P12: begin
          if (pass_end) begin
            op_q  <= OP_P34;
            state <= S_P34;
          end
        end
        S_P34: begin
          if (pass_end) begin
            op_q  <= OP_P56;
            state <= S_P56;
          end
        end
        S_P56: begin
          if (pass_end) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### rtl/tlca_check.sv
// port-level checker for the traffic lane step unit and its bind
`include "traffic_lane_ca_step_unit_assert.svh"

module tlca_check (
  input logic                        clk,
  input logic                        rst,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [tlca_pkg::POS_W-1:0]  out_position,
  input logic [tlca_pkg::POS_W-1:0]  out_prev_position,
  input logic [tlca_pkg::SPD_W-1:0]  out_speed,
  input logic [tlca_pkg::CNT_W-1:0]  car_total,
  input logic                        rejected
);
  import tlca_pkg::*;

  `TLCA_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
  `TLCA_ASSERT_NOW(a_total_range, out_valid, car_total <= CNT_W'(MAX_CARS))
  `TLCA_ASSERT_NOW(a_reject_zero, out_valid && rejected, (out_position == '0) && (out_prev_position == '0) && (out_speed == '0))
  `TLCA_ASSERT_NOW(a_empty_reads, out_valid && (car_total == '0), (out_position == '0) && (out_speed == '0))

endmodule

bind traffic_lane_ca_step_unit tlca_check u_check (.*);
